@@ design/acc4_pkg.sv @@
// Shared types, opcodes and field widths for the 4-bit accumulator step unit.
package acc4_pkg;

  localparam int unsigned INSTR_W = 8;
  localparam int unsigned PC_W    = 8;
  localparam int unsigned DATA_W  = 4;
  localparam int unsigned RF_AW   = 3;
  localparam int unsigned RF_DEPTH = 1 << RF_AW;

  localparam logic [3:0] OP_ADD   = 4'h0;
  localparam logic [3:0] OP_NAND  = 4'h1;
  localparam logic [3:0] OP_XOR   = 4'h2;
  localparam logic [3:0] OP_BAD   = 4'h3;
  localparam logic [3:0] OP_ADDI  = 4'h4;
  localparam logic [3:0] OP_NANDI = 4'h5;
  localparam logic [3:0] OP_XORI  = 4'h6;
  localparam logic [3:0] OP_MOVE  = 4'h7;

  localparam logic [1:0] ALU_ADD  = 2'd0;
  localparam logic [1:0] ALU_NAND = 2'd1;

  localparam int unsigned BRANCH_BIT = 7;
  localparam int unsigned IMM_BIT    = 6;
  localparam int unsigned STORE_BIT  = 3;
  localparam int unsigned SIGN_BIT   = 3;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic [DATA_W-1:0] acc;
    logic              taken;
    logic              bad;
    logic              rf_we;
  } exec_t;

endpackage

@@ design/acc4_exec.sv @@
// Decode and execute unit for one instruction byte.
module acc4_exec (
  input  logic [acc4_pkg::INSTR_W-1:0] instr,
  input  logic [acc4_pkg::PC_W-1:0]    pc,
  input  logic [acc4_pkg::DATA_W-1:0]  acc,
  input  logic [acc4_pkg::DATA_W-1:0]  rf_data,
  output acc4_pkg::exec_t              result
);

  logic [3:0]                  op;
  logic [acc4_pkg::DATA_W-1:0] operand;
  logic [acc4_pkg::DATA_W-1:0] alu_out;

  assign op      = instr[7:4];
  assign operand = instr[acc4_pkg::IMM_BIT] ? instr[acc4_pkg::DATA_W-1:0] : rf_data;

  always_comb begin
    case (op[1:0])
      acc4_pkg::ALU_ADD:  alu_out = acc + operand;
      acc4_pkg::ALU_NAND: alu_out = ~(acc & operand);
      default:            alu_out = acc ^ operand;
    endcase
  end

  always_comb begin
    result.next_pc = pc + acc4_pkg::PC_W'(1);
    result.acc     = acc;
    result.taken   = 1'b0;
    result.bad     = 1'b0;
    result.rf_we   = 1'b0;
    if (instr[acc4_pkg::BRANCH_BIT]) begin
      if (acc[acc4_pkg::SIGN_BIT]) begin
        result.next_pc = {1'b0, instr[acc4_pkg::PC_W-2:0]};
        result.taken   = 1'b1;
      end
    end else begin
      case (op)
        acc4_pkg::OP_BAD: result.bad = 1'b1;
        acc4_pkg::OP_MOVE: begin
          if (instr[acc4_pkg::STORE_BIT]) result.rf_we = 1'b1;
          else result.acc = rf_data;
        end
        acc4_pkg::OP_ADD, acc4_pkg::OP_NAND, acc4_pkg::OP_XOR,
        acc4_pkg::OP_ADDI, acc4_pkg::OP_NANDI, acc4_pkg::OP_XORI: result.acc = alu_out;
        default: result.acc = acc;
      endcase
    end
  end

endmodule

@@ design/four_bit_accumulator_cpu_step_top.sv @@
// Top level: input register, execute stage with architectural state, result register.
//
//   channel  signals                                    direction
//   in       in_valid, in_stall, instruction            item in
//   out      out_valid, out_stall, next_pc, accumulator,
//            branch_taken, illegal                      result out
//
// One instruction per cycle while out_stall is low; each passes the input register, then the result register.
// The execute stage updates pc, accumulator and register file as it fills the result register.
// Reset clears pc, accumulator, all eight register file entries and both valid flags.
// A stalled result holds; one more instruction waits in the input register, then in_stall rises.
module four_bit_accumulator_cpu_step_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [acc4_pkg::INSTR_W-1:0]  instruction,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [acc4_pkg::PC_W-1:0]     next_pc,
  output logic [acc4_pkg::DATA_W-1:0]   accumulator,
  output logic                          branch_taken,
  output logic                          illegal
);

  logic                         in_reg_valid;
  logic [acc4_pkg::INSTR_W-1:0] in_reg_instr;
  logic                         advance;
  logic                         out_hold;

  logic [acc4_pkg::PC_W-1:0]    pc;
  logic [acc4_pkg::DATA_W-1:0]  acc;
  logic [acc4_pkg::DATA_W-1:0]  rf [acc4_pkg::RF_DEPTH];
  logic [acc4_pkg::RF_AW-1:0]   sel;
  acc4_pkg::exec_t              exec;

  assign out_hold = out_valid && out_stall;
  assign advance  = in_reg_valid && !out_hold;
  assign in_stall = in_reg_valid && out_hold;
  assign sel      = in_reg_instr[acc4_pkg::RF_AW-1:0];

  acc4_exec u_exec (
    .instr   (in_reg_instr),
    .pc      (pc),
    .acc     (acc),
    .rf_data (rf[sel]),
    .result  (exec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_reg_instr <= instruction;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      acc <= '0;
      for (int i = 0; i < acc4_pkg::RF_DEPTH; i++) begin
        rf[i] <= '0;
      end
    end else if (advance) begin
      pc  <= exec.next_pc;
      acc <= exec.acc;
      if (exec.rf_we) begin
        rf[sel] <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      next_pc      <= exec.next_pc;
      accumulator  <= exec.acc;
      branch_taken <= exec.taken;
      illegal      <= exec.bad;
    end
  end

endmodule

@@ design/acc4_checker.sv @@
// Port-level checker for the accumulator step unit, bound to the top level.
module acc4_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [acc4_pkg::PC_W-1:0]    next_pc,
  input logic [acc4_pkg::DATA_W-1:0]  accumulator,
  input logic                         branch_taken,
  input logic                         illegal
);

  logic [acc4_pkg::PC_W-1:0]   last_pc;
  logic [acc4_pkg::DATA_W-1:0] last_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pc  <= '0;
      last_acc <= '0;
    end else if (out_valid && !out_stall) begin
      last_pc  <= next_pc;
      last_acc <= accumulator;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(accumulator))
    else $error("stalled result changed");

  a_branch: assert property (@(posedge clk) disable iff (rst)
    out_valid && branch_taken |-> !next_pc[7] && !illegal && last_acc[3])
    else $error("bad taken branch");

  a_seq_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !branch_taken |-> next_pc == last_pc + 8'd1)
    else $error("pc did not advance by one");

  a_illegal_nop: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> accumulator == last_acc)
    else $error("illegal opcode changed accumulator");

endmodule

bind four_bit_accumulator_cpu_step_top acc4_checker u_acc4_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .next_pc      (next_pc),
  .accumulator  (accumulator),
  .branch_taken (branch_taken),
  .illegal      (illegal)
);
